// ----- rtl/hmcs_pkg.sv -----
package hmcs_pkg;

  // Default sizing of the block.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field and register widths.
  localparam int GW_BITS       = 11;
  localparam int GH_BITS       = 13;
  localparam int ROW_BITS      = 12;
  localparam int COL_OUT_BITS  = 10;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  // Register reset values and the height limit.
  localparam int GRID_WIDTH_RST  = 1024;
  localparam int GRID_HEIGHT_RST = 1024;
  localparam int MAX_HEIGHT      = 4096;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  // The divisor is the number of points in the cross, 1 to 5.
  localparam int CNT_W = 3;

  // Quotient bits the divider resolves per clock.
  localparam int DIGITS_PER_CYCLE = 8;

  // Results one sample can produce, in delivery order.
  localparam logic [1:0] RES_NORTH = 2'd0;
  localparam logic [1:0] RES_WEST  = 2'd1;
  localparam logic [1:0] RES_SELF  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUMS,
    ST_START,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- rtl/hmcs_div.sv -----
module hmcs_div #(
  parameter int SUM_BITS = hmcs_pkg::SAMPLE_BITS_DEF + 3,
  parameter int Q_BITS   = hmcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hmcs_pkg::div_req_t     req,
  input  logic [SUM_BITS-1:0]    dividend,
  output logic                   done,
  output logic [Q_BITS-1:0]      quotient
);

  localparam int DPC   = hmcs_pkg::DIGITS_PER_CYCLE;
  localparam int STEPS = (SUM_BITS + DPC - 1) / DPC;
  localparam int PADW  = STEPS * DPC;
  localparam int CNTB  = $clog2(STEPS + 1);
  localparam int CW    = hmcs_pkg::CNT_W;

  // The shift register starts with the dividend and fills with quotient bits.
  logic [PADW-1:0] sh;
  logic [PADW-1:0] sh_next;
  logic [CW-1:0]   rem;
  logic [CW-1:0]   rem_next;
  logic [CW-1:0]   dv;
  logic [CNTB-1:0] cnt;

  always_comb begin : digit_steps
    logic [CW:0] t;
    logic        qb;
    sh_next  = sh;
    rem_next = rem;
    for (int i = 0; i < DPC; i++) begin
      t  = {rem_next, sh_next[PADW-1]};
      qb = 1'b0;
      if (t >= {1'b0, dv}) begin
        t  = t - {1'b0, dv};
        qb = 1'b1;
      end
      rem_next = t[CW-1:0];
      sh_next  = {sh_next[PADW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CNTB'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNTB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh  <= PADW'(dividend);
      rem <= '0;
      dv  <= req.divisor;
    end else if (cnt != '0) begin
      sh  <= sh_next;
      rem <= rem_next;
    end
  end

  assign done     = (cnt == '0);
  assign quotient = sh[Q_BITS-1:0];

endmodule

// ----- rtl/heightmap_cross_smoothing.sv -----
// Five-point cross mean over a height grid streamed in raster order.
// Samples enter on the input channel (in_valid / in_stall / height_sample);
// results leave on the output channel (out_valid / out_stall and the result
// fields). A beat moves when valid is high and stall is low. The grid size
// is set through the configuration channel (cfg_valid / cfg_ready with
// cfg_index and cfg_data); a write to either register restarts the grid at
// row 0, column 0. Writes are taken only while no sample is in flight.
// Sample (r,c) yields the result for (r-1,c); on the last row also (r,c-1),
// and on the final sample also (r,c). Each result is the sum of the point
// and its neighbors inside the grid, divided by their count with truncation.
// Sequence: an accepted sample passes the sum state, then each of its 0 to 3
// results passes a start state and STEPS passes of the digit-serial divider,
// where STEPS is (SAMPLE_BITS + 3) / 8 rounded up, before it is loaded into
// the output register. The row stores are read as a sample is accepted and
// written back in the cycle after, before the next sample can be accepted.
// A stalled receiver holds the output register; the divider result waits and
// no new sample is accepted until the last result of the current one has
// been loaded into the output register.
// Reset clears the counters, window and handshake state and restores both
// grid registers to 1024; the row stores keep their contents.

module heightmap_cross_smoothing #(
  parameter int MAX_WIDTH   = hmcs_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = hmcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SAMPLE_BITS-1:0]             height_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [SAMPLE_BITS-1:0]             smoothed_height,
  output logic [hmcs_pkg::ROW_BITS-1:0]      out_row,
  output logic [hmcs_pkg::COL_OUT_BITS-1:0]  out_col,
  output logic                               last_of_run,
  output logic                               grid_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hmcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hmcs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int GW    = hmcs_pkg::GW_BITS;
  localparam int GH    = hmcs_pkg::GH_BITS;
  localparam int RB    = hmcs_pkg::ROW_BITS;
  localparam int NW    = hmcs_pkg::CNT_W;
  localparam int WCB   = (CW + 1 > GW) ? CW + 1 : GW;
  localparam int SUMW  = SAMPLE_BITS + 3;

  hmcs_pkg::state_t   state;
  hmcs_pkg::state_t   state_next;
  hmcs_pkg::div_req_t div_req;

  // Configuration and position in the grid.
  logic [GW-1:0]  grid_width;
  logic [GH-1:0]  grid_height;
  logic [RB-1:0]  row_count;
  logic [CW-1:0]  col_count;
  logic [WCB-1:0] weff;
  logic [GH-1:0]  heff;
  logic [CW-1:0]  c_eff;
  logic [CW-1:0]  c_eff_p1;

  // The two row stores: previous row and the one before it.
  logic [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];

  // The sample being worked on and what was read for it.
  logic [SAMPLE_BITS-1:0] s_q;
  logic [RB-1:0]          r_q;
  logic [CW-1:0]          c_q;
  logic [SAMPLE_BITS-1:0] up_q;
  logic [SAMPLE_BITS-1:0] up2_q;
  logic [SAMPLE_BITS-1:0] upe_q;

  // Window: north-west of the current sample, west, and two to the west.
  logic [SAMPLE_BITS-1:0] w0;
  logic [SAMPLE_BITS-1:0] w1;
  logic [SAMPLE_BITS-1:0] w2;

  logic           in_acc;
  logic           cfg_acc;
  logic [WCB-1:0] c_wide;
  logic           has_w;
  logic           has_w2;
  logic           has_e;
  logic           has_n;
  logic           has_n2;
  logic           last_row;
  logic           final_pt;
  logic [2:0]     new_mask;

  logic [SUMW-1:0] sum_north;
  logic [SUMW-1:0] sum_west;
  logic [SUMW-1:0] sum_self;
  logic [NW-1:0]   n_north;
  logic [NW-1:0]   n_west;
  logic [NW-1:0]   n_self;

  logic [SUMW-1:0] sum_q [3];
  logic [NW-1:0]   n_q [3];
  logic [2:0]      rmask;
  logic [1:0]      cur_idx;
  logic [2:0]      rest_mask;
  logic            last_res;
  logic            load_out;

  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_quot;

  assign cfg_ready = (state == hmcs_pkg::ST_IDLE);
  assign in_stall  = (state != hmcs_pkg::ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // A zero register counts as one; oversize values clamp to the limits.
  always_comb begin
    if (grid_width == '0) begin
      weff = WCB'(1);
    end else if (WCB'(grid_width) > WCB'(MAX_WIDTH)) begin
      weff = WCB'(MAX_WIDTH);
    end else begin
      weff = WCB'(grid_width);
    end
    if (grid_height == '0) begin
      heff = GH'(1);
    end else if (grid_height > GH'(hmcs_pkg::MAX_HEIGHT)) begin
      heff = GH'(hmcs_pkg::MAX_HEIGHT);
    end else begin
      heff = grid_height;
    end
  end

  always_comb begin
    if (WCB'(col_count) >= weff) begin
      c_eff = CW'(weff - WCB'(1));
    end else begin
      c_eff = col_count;
    end
  end

  assign c_eff_p1 = c_eff + CW'(1);

  // Neighbor presence for the sample held in s_q.
  assign c_wide   = WCB'(c_q);
  assign has_w    = (c_q != '0);
  assign has_w2   = (c_wide >= WCB'(2));
  assign has_e    = ((c_wide + WCB'(1)) < weff);
  assign has_n    = (r_q != '0);
  assign has_n2   = (r_q >= RB'(2));
  assign last_row = ((GH'(r_q) + GH'(1)) >= heff);
  assign final_pt = last_row && ((c_wide + WCB'(1)) >= weff);

  always_comb begin
    new_mask = '0;
    new_mask[hmcs_pkg::RES_NORTH] = has_n;
    new_mask[hmcs_pkg::RES_WEST]  = last_row && has_w;
    new_mask[hmcs_pkg::RES_SELF]  = final_pt;
  end

  // The point above is complete once its south neighbor arrives.
  assign sum_north = SUMW'(up_q) + SUMW'(s_q)
                   + (has_w  ? SUMW'(w0)    : '0)
                   + (has_n2 ? SUMW'(up2_q) : '0)
                   + (has_e  ? SUMW'(upe_q) : '0);
  assign n_north   = NW'(2) + NW'(has_w) + NW'(has_n2) + NW'(has_e);

  // On the last row the point to the west is complete once its east arrives.
  assign sum_west  = SUMW'(w1) + SUMW'(s_q)
                   + (has_w2 ? SUMW'(w2) : '0)
                   + (has_n  ? SUMW'(w0) : '0);
  assign n_west    = NW'(2) + NW'(has_w2) + NW'(has_n);

  // The final sample of the grid closes itself.
  assign sum_self  = SUMW'(s_q)
                   + (has_w ? SUMW'(w1)   : '0)
                   + (has_n ? SUMW'(up_q) : '0);
  assign n_self    = NW'(1) + NW'(has_w) + NW'(has_n);

  // Results still owed for this sample go out in fixed order.
  always_comb begin
    if (rmask[hmcs_pkg::RES_NORTH]) begin
      cur_idx = hmcs_pkg::RES_NORTH;
    end else if (rmask[hmcs_pkg::RES_WEST]) begin
      cur_idx = hmcs_pkg::RES_WEST;
    end else begin
      cur_idx = hmcs_pkg::RES_SELF;
    end
  end

  assign rest_mask = rmask & ~(3'b001 << cur_idx);
  assign last_res  = (rest_mask == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    div_req.start   = 1'b0;
    div_req.divisor = n_q[cur_idx];
    load_out        = 1'b0;
    case (state)
      hmcs_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = hmcs_pkg::ST_SUMS;
        end
      end
      hmcs_pkg::ST_SUMS: begin
        if (new_mask != '0) begin
          state_next = hmcs_pkg::ST_START;
        end else begin
          state_next = hmcs_pkg::ST_IDLE;
        end
      end
      hmcs_pkg::ST_START: begin
        div_req.start = 1'b1;
        state_next    = hmcs_pkg::ST_DIV;
      end
      hmcs_pkg::ST_DIV: begin
        if (div_done && (!out_valid || !out_stall)) begin
          load_out = 1'b1;
          if (last_res) begin
            state_next = hmcs_pkg::ST_IDLE;
          end else begin
            state_next = hmcs_pkg::ST_START;
          end
        end
      end
      default: begin
        state_next = hmcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers and the raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GW'(hmcs_pkg::GRID_WIDTH_RST);
      grid_height <= GH'(hmcs_pkg::GRID_HEIGHT_RST);
      row_count   <= '0;
      col_count   <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        hmcs_pkg::REG_GRID_WIDTH: begin
          grid_width <= cfg_data[GW-1:0];
          row_count  <= '0;
          col_count  <= '0;
        end
        hmcs_pkg::REG_GRID_HEIGHT: begin
          grid_height <= cfg_data[GH-1:0];
          row_count   <= '0;
          col_count   <= '0;
        end
        default: begin
        end
      endcase
    end else if (state == hmcs_pkg::ST_SUMS) begin
      if (final_pt) begin
        row_count <= '0;
        col_count <= '0;
      end else if ((c_wide + WCB'(1)) >= weff) begin
        row_count <= r_q + RB'(1);
        col_count <= '0;
      end else begin
        col_count <= c_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w0    <= '0;
      w1    <= '0;
      w2    <= '0;
      rmask <= '0;
    end else if (state == hmcs_pkg::ST_SUMS) begin
      w2    <= w1;
      w1    <= s_q;
      w0    <= up_q;
      rmask <= new_mask;
    end else if (load_out) begin
      rmask <= rest_mask;
    end
  end

  // Row stores: read on acceptance, written back during the sum cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_q  <= newer_mem[c_eff];
      upe_q <= newer_mem[c_eff_p1];
      up2_q <= older_mem[c_eff];
    end
    if (state == hmcs_pkg::ST_SUMS) begin
      newer_mem[c_q] <= s_q;
      older_mem[c_q] <= up_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_q <= height_sample;
      r_q <= row_count;
      c_q <= c_eff;
    end
    if (state == hmcs_pkg::ST_SUMS) begin
      sum_q[hmcs_pkg::RES_NORTH] <= sum_north;
      sum_q[hmcs_pkg::RES_WEST]  <= sum_west;
      sum_q[hmcs_pkg::RES_SELF]  <= sum_self;
      n_q[hmcs_pkg::RES_NORTH]   <= n_north;
      n_q[hmcs_pkg::RES_WEST]    <= n_west;
      n_q[hmcs_pkg::RES_SELF]    <= n_self;
    end
  end

  hmcs_div #(
    .SUM_BITS (SUMW),
    .Q_BITS   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (sum_q[cur_idx]),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Output register: holds a result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      smoothed_height <= div_quot;
      out_row         <= (cur_idx == hmcs_pkg::RES_NORTH) ? (r_q - RB'(1)) : r_q;
      out_col         <= hmcs_pkg::COL_OUT_BITS'((cur_idx == hmcs_pkg::RES_WEST) ?
                                                 (c_q - CW'(1)) : c_q);
      last_of_run     <= last_res;
      grid_done       <= (cur_idx == hmcs_pkg::RES_SELF);
    end
  end

  // The divider is only started when it has finished the previous result.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_done)
    else $error("divider started while busy");

  // An accepted sample always goes to the sum cycle next.
  a_acc_sums: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == hmcs_pkg::ST_SUMS))
    else $error("accepted sample did not reach the sum cycle");

  // While dividing there is always a result still owed.
  a_owed: assert property (@(posedge clk) disable iff (rst)
    ((state == hmcs_pkg::ST_START) || (state == hmcs_pkg::ST_DIV)) |-> (rmask != '0))
    else $error("divide phase with no pending result");

  // The column position stays inside the configured row.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (WCB'(col_count) < weff))
    else $error("column counter beyond grid width");

endmodule
